@@ design/light_adc_average_to_lux_macros.svh @@
// assertion macros shared by the light sensor checker
// no dependencies; included by the checker file
`ifndef LIGHT_ADC_AVERAGE_TO_LUX_MACROS_SVH
`define LIGHT_ADC_AVERAGE_TO_LUX_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LALUX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("light sensor check failed");

// next-cycle implication, disabled while reset is low
`define LALUX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("light sensor check failed");

`endif

@@ design/lalux_pkg.sv @@
// shared types, constants and the adc-to-lux breakpoint table
// no dependencies; used by every module of the light sensor block
`timescale 1ns / 1ps

package lalux_pkg;

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 20;
	localparam int CNT_W    = 8;
	localparam int PCT_W    = 7;
	localparam int LUX_W    = 15;

	// group size limits
	localparam logic [CNT_W-1:0] MAX_SAMPLES   = 8'd255;
	localparam logic [CNT_W-1:0] SAMPLES_RESET = 8'd10;

	// mean saturation and brightness scaling (avg / 40 as avg * 6554 >> 18)
	localparam logic [SAMPLE_W-1:0] AVG_MAX     = 12'd4095;
	localparam logic [PCT_W-1:0]    PCT_FULL    = 7'd100;
	localparam int                  RECIP_SHIFT = 18;
	localparam int                  RECIP_W     = 13;
	localparam logic [RECIP_W-1:0]  RECIP_40    = 13'd6554;
	localparam int                  PCT_PROD_W  = SAMPLE_W + RECIP_W;

	// shared divider operand widths
	localparam int DIVIDEND_W = LUX_W + SAMPLE_W;
	localparam int DIVISOR_W  = SAMPLE_W;
	localparam int DSTEP_W    = $clog2(DIVIDEND_W + 1);

	// breakpoint table
	localparam int TABLE_POINTS = 21;
	localparam int IDX_W        = $clog2(TABLE_POINTS);

	localparam logic [SAMPLE_W-1:0] LUX_CODE [TABLE_POINTS] = '{
		12'd0,    12'd10,   12'd20,   12'd40,   12'd60,
		12'd80,   12'd100,  12'd130,  12'd160,  12'd200,
		12'd300,  12'd500,  12'd1000, 12'd1500, 12'd2000,
		12'd2500, 12'd3000, 12'd3500, 12'd3800, 12'd4000,
		12'd4095
	};

	localparam logic [LUX_W-1:0] LUX_LEVEL [TABLE_POINTS] = '{
		15'd30000, 15'd28000, 15'd25000, 15'd20000, 15'd12000,
		15'd7000,  15'd4000,  15'd2500,  15'd1500,  15'd600,
		15'd520,   15'd450,   15'd100,   15'd70,    15'd40,
		15'd30,    15'd25,    15'd20,    15'd10,    15'd5,
		15'd0
	};

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_SAT,
		ST_PCT,
		ST_SEARCH,
		ST_MUL,
		ST_INTERP,
		ST_OUT
	} lalux_state_t;

	// divider request and status
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} lalux_div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} lalux_div_rsp_t;

endpackage

@@ design/lalux_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on lalux_pkg for operand widths and request/status types
`timescale 1ns / 1ps

module lalux_div
	import lalux_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  lalux_div_req_t req,
	output lalux_div_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [DSTEP_W-1:0]    step_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// one restoring step
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= DSTEP_W'(DIVIDEND_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == DSTEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands, partial remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ design/light_adc_average_to_lux.sv @@
// Light sensor averager: sums sample_count 12-bit adc samples (0 acts as 1) and, on the sample
// that closes a group, returns the truncated mean saturated at 4095, a brightness percentage
// (100 - mean/40, floored at 0) and an illuminance in lux interpolated over a 21-point
// breakpoint table, clamped at the table ends. A sample that does not close a group leaves
// in_ready high. A closing sample keeps in_ready low after its transfer for a pass of the
// shared restoring divider for the mean, saturation and scaling, a segment search of one
// breakpoint per cycle, one multiply and a second divider pass for the interpolation step,
// plus any wait for a full output register. Means at the table ends skip the search and the
// second pass. A finished result sits in an output register, so the next group is taken while
// it waits. sample_count is to be written through the cfg channel only while the block is
// idle; the block itself does not enforce this. Depends on lalux_pkg and lalux_div.
`timescale 1ns / 1ps

module light_adc_average_to_lux
	import lalux_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CNT_W-1:0]    cfg_data,
	// sample input
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	// result output
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] average,
	output logic [PCT_W-1:0]    brightness_percent,
	output logic [LUX_W-1:0]    lux_value
);

	lalux_state_t state_q;
	lalux_state_t state_d;

	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      taken_q;
	logic [CNT_W-1:0]      group_n;
	logic [CNT_W:0]        taken_inc;
	logic [SUM_W-1:0]      sum_inc;
	logic                  in_xfer;
	logic                  group_done;

	logic [SAMPLE_W-1:0]   avg_q;
	logic [PCT_W-1:0]      pct_q;
	logic [LUX_W-1:0]      lux_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      idx_nxt;
	logic [SAMPLE_W-1:0]   off_q;
	logic [SAMPLE_W-1:0]   span_q;
	logic [LUX_W-1:0]      base_q;
	logic [LUX_W-1:0]      delta_q;
	logic                  rise_q;
	logic                  seg_hit;
	logic                  at_end;
	logic [DIVIDEND_W-1:0] seg_prod;
	logic [PCT_PROD_W-1:0] pct_prod;
	logic [PCT_W-1:0]      tens;

	logic                  out_valid_q;
	logic                  out_free;
	logic [SAMPLE_W-1:0]   average_q;
	logic [PCT_W-1:0]      pct_out_q;
	logic [LUX_W-1:0]      lux_out_q;

	lalux_div_req_t        div_req;
	lalux_div_rsp_t        div_rsp;

	// shared divider
	lalux_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// group size, a zero count acts as one
	always_comb begin
		group_n = count_q;
		if (count_q == '0) begin
			group_n = CNT_W'(1);
		end
	end

	// accumulation and group close
	assign in_ready   = (state_q == ST_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign taken_inc  = {1'b0, taken_q} + 1'b1;
	assign sum_inc    = sum_q + SUM_W'(sample);
	assign group_done = (taken_inc >= {1'b0, group_n}) || (taken_inc[CNT_W-1:0] == '0);

	// brightness: avg / 40 by reciprocal multiply
	assign pct_prod = PCT_PROD_W'(avg_q) * PCT_PROD_W'(RECIP_40);
	assign tens     = pct_prod[RECIP_SHIFT +: PCT_W];

	// segment search and interpolation step
	assign idx_nxt  = idx_q + 1'b1;
	assign seg_hit  = avg_q <= LUX_CODE[idx_nxt];
	assign at_end   = (avg_q <= LUX_CODE[0]) || (avg_q >= LUX_CODE[TABLE_POINTS-1]);
	assign seg_prod = DIVIDEND_W'(delta_q) * DIVIDEND_W'(off_q);

	assign out_free = !out_valid_q || out_ready;

	// sequencer next state and divider requests
	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = DIVIDEND_W'(sum_inc);
		div_req.divisor  = DIVISOR_W'(group_n);
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && group_done) begin
					div_req.start = 1'b1;
					state_d       = ST_AVG;
				end
			end
			ST_AVG: begin
				if (div_rsp.done) begin
					state_d = ST_SAT;
				end
			end
			ST_SAT: begin
				state_d = ST_PCT;
			end
			ST_PCT: begin
				state_d = at_end ? ST_OUT : ST_SEARCH;
			end
			ST_SEARCH: begin
				if (seg_hit) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				div_req.start    = 1'b1;
				div_req.dividend = seg_prod;
				div_req.divisor  = span_q;
				state_d          = ST_INTERP;
			end
			ST_INTERP: begin
				if (div_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= SAMPLES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// running sum and sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			taken_q <= '0;
		end else if (in_xfer) begin
			if (group_done) begin
				sum_q   <= '0;
				taken_q <= '0;
			end else begin
				sum_q   <= sum_inc;
				taken_q <= taken_inc[CNT_W-1:0];
			end
		end
	end

	// result datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SAT: begin
				if (div_rsp.quotient > DIVIDEND_W'(AVG_MAX)) begin
					avg_q <= AVG_MAX;
				end else begin
					avg_q <= div_rsp.quotient[SAMPLE_W-1:0];
				end
			end
			ST_PCT: begin
				pct_q <= (tens >= PCT_FULL) ? '0 : PCT_FULL - tens;
				idx_q <= '0;
				if (avg_q <= LUX_CODE[0]) begin
					lux_q <= LUX_LEVEL[0];
				end else begin
					lux_q <= LUX_LEVEL[TABLE_POINTS-1];
				end
			end
			ST_SEARCH: begin
				if (seg_hit) begin
					off_q  <= avg_q - LUX_CODE[idx_q];
					span_q <= LUX_CODE[idx_nxt] - LUX_CODE[idx_q];
					base_q <= LUX_LEVEL[idx_q];
					rise_q <= LUX_LEVEL[idx_nxt] >= LUX_LEVEL[idx_q];
					if (LUX_LEVEL[idx_nxt] >= LUX_LEVEL[idx_q]) begin
						delta_q <= LUX_LEVEL[idx_nxt] - LUX_LEVEL[idx_q];
					end else begin
						delta_q <= LUX_LEVEL[idx_q] - LUX_LEVEL[idx_nxt];
					end
				end else begin
					idx_q <= idx_nxt;
				end
			end
			ST_INTERP: begin
				if (div_rsp.done) begin
					if (rise_q) begin
						lux_q <= base_q + div_rsp.quotient[LUX_W-1:0];
					end else begin
						lux_q <= base_q - div_rsp.quotient[LUX_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			average_q <= avg_q;
			pct_out_q <= pct_q;
			lux_out_q <= lux_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign average            = average_q;
	assign brightness_percent = pct_out_q;
	assign lux_value          = lux_out_q;

endmodule

@@ design/lalux_checker.sv @@
// port-level checks for the light sensor block, bound to the top level
// depends on lalux_pkg and light_adc_average_to_lux_macros.svh
`timescale 1ns / 1ps

`include "light_adc_average_to_lux_macros.svh"

module lalux_checker
	import lalux_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [SAMPLE_W-1:0] sample,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SAMPLE_W-1:0] average,
	input logic [PCT_W-1:0]    brightness_percent,
	input logic [LUX_W-1:0]    lux_value
);

	// a waiting sample holds until its transfer
	`LALUX_ASSERT_NXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(sample))

	// a stalled result keeps its average and lux until its transfer
	`LALUX_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(average) && $stable(lux_value))

	// results stay inside their ranges
	`LALUX_ASSERT_IMP(a_out_range, clk, arst_n, out_valid, brightness_percent <= PCT_FULL && lux_value <= LUX_LEVEL[0])

	// bright end of the table and full brightness
	`LALUX_ASSERT_IMP(a_bright_end, clk, arst_n, out_valid && average == '0, lux_value == LUX_LEVEL[0] && brightness_percent == PCT_FULL)

	// dark end of the table and zero brightness
	`LALUX_ASSERT_IMP(a_dark_end, clk, arst_n, out_valid && average == AVG_MAX, lux_value == '0 && brightness_percent == '0)

endmodule

bind light_adc_average_to_lux lalux_checker u_lalux_checker (.*);

@@ dv/light_adc_average_to_lux_tb.sv @@
// testbench for the light sensor averager: drives sample groups and sample_count writes,
// predicts mean, brightness and interpolated lux, and checks every result transfer in order
// depends on lalux_pkg and light_adc_average_to_lux
`timescale 1ns / 1ps

module light_adc_average_to_lux_tb;
	import lalux_pkg::*;

	localparam int IDLE_LIMIT   = 3000;
	localparam int SETTLE_TICKS = 120;
	localparam int NPTS         = 21;

	// adc code and lux of each breakpoint, bright end first
	localparam int unsigned BP_CODE [NPTS] = '{
		0, 10, 20, 40, 60, 80, 100, 130, 160, 200, 300,
		500, 1000, 1500, 2000, 2500, 3000, 3500, 3800, 4000, 4095
	};
	localparam int unsigned BP_LUX [NPTS] = '{
		30000, 28000, 25000, 20000, 12000, 7000, 4000, 2500, 1500, 600, 520,
		450, 100, 70, 40, 30, 25, 20, 10, 5, 0
	};

	typedef struct packed {
		logic [SAMPLE_W-1:0] average;
		logic [PCT_W-1:0]    pct;
		logic [LUX_W-1:0]    lux;
	} lux_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SAMPLE_W-1:0] average;
	logic [PCT_W-1:0]    brightness_percent;
	logic [LUX_W-1:0]    lux_value;

	// predictor state
	logic [CNT_W-1:0]    group_size_reg = SAMPLES_RESET;
	logic [SUM_W-1:0]    group_sum = '0;
	logic [CNT_W-1:0]    group_fill = '0;
	lux_result_t         lux_expect_q [$];

	int                  mismatch_count = 0;
	int                  idle_cycles = 0;
	int                  rx_stall_left = 0;
	int                  rx_roll;
	bit                  tx_gaps_on = 1'b1;
	bit                  rx_gaps_on = 1'b1;
	int unsigned         sample_level = 0;

	light_adc_average_to_lux dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.sample             (sample),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.average            (average),
		.brightness_percent (brightness_percent),
		.lux_value          (lux_value)
	);

	always #5 clk = ~clk;

	// piecewise linear lux, step truncated towards zero, clamped at both ends
	function automatic logic [LUX_W-1:0] lux_from_code(input int unsigned v);
		int unsigned span, off, l1, l2, k;
		if (v <= BP_CODE[0]) return LUX_W'(BP_LUX[0]);
		if (v >= BP_CODE[NPTS-1]) return LUX_W'(BP_LUX[NPTS-1]);
		for (k = 0; k < NPTS - 1; k++) begin
			if (v >= BP_CODE[k] && v <= BP_CODE[k+1]) begin
				span = BP_CODE[k+1] - BP_CODE[k];
				off  = v - BP_CODE[k];
				l1   = BP_LUX[k];
				l2   = BP_LUX[k+1];
				if (span == 0) return LUX_W'(l1);
				if (l2 >= l1) return LUX_W'(l1 + ((l2 - l1) * off) / span);
				return LUX_W'(l1 - ((l1 - l2) * off) / span);
			end
		end
		return '0;
	endfunction

	// fold one sample into the running group, queue a result when the group closes
	task automatic absorb_sample(input logic [SAMPLE_W-1:0] s);
		int unsigned n, mean, tens;
		lux_result_t r;
		n = (group_size_reg == 0) ? 1 : group_size_reg;
		group_sum  = group_sum + s;
		group_fill = group_fill + 1'b1;
		if (group_fill < n && group_fill != 0) return;
		mean = group_sum / n;
		if (mean > AVG_MAX) mean = AVG_MAX;
		group_sum  = '0;
		group_fill = '0;
		tens = mean / 40;
		r.average = mean[SAMPLE_W-1:0];
		r.pct     = (tens >= 100) ? '0 : PCT_W'(100 - tens);
		r.lux     = lux_from_code(mean);
		lux_expect_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	// one sample transfer, with an optional gap in front of it
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		int gap, roll;
		gap = 0;
		if (tx_gaps_on) begin
			roll = $urandom_range(0, 99);
			if (roll >= 95) gap = $urandom_range(10, 40);
			else if (roll >= 65) gap = $urandom_range(1, 3);
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		absorb_sample(s);
	endtask

	// hold the sender until every queued result is out and the block has settled
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (lux_expect_q.size() != 0) @(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic write_group_size(input logic [CNT_W-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		group_size_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// samples cluster around a level that moves now and then, often near a breakpoint
	function automatic logic [SAMPLE_W-1:0] next_sample();
		int v, roll;
		roll = $urandom_range(0, 15);
		if ($urandom_range(0, 7) == 0) begin
			if ($urandom_range(0, 1) == 0)
				sample_level = BP_CODE[$urandom_range(0, NPTS-1)];
			else
				sample_level = $urandom_range(0, 4095);
		end
		if (roll == 0) return SAMPLE_W'($urandom_range(0, 4095));
		if (roll == 1) return '0;
		if (roll == 2) return AVG_MAX;
		v = int'(sample_level) + $urandom_range(0, 40) - 20;
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic run_random_samples(input int count);
		int k;
		for (k = 0; k < count; k++) begin
			if (k % 64 == 0) begin
				tx_gaps_on = ($urandom_range(0, 3) != 0);
				rx_gaps_on = ($urandom_range(0, 3) != 0);
			end
			send_sample(next_sample());
		end
	endtask

	// reset group size of ten, all samples at full scale
	task automatic test_reset_group_size();
		repeat (10) send_sample(AVG_MAX);
	endtask

	// one-sample groups at the bright table end, next to the dark end and over some bit patterns
	task automatic test_single_sample_groups();
		write_group_size(8'd1);
		send_sample(12'd0);
		send_sample(12'd10);
		send_sample(12'd15);
		send_sample(12'd4000);
		send_sample(12'd4094);
		send_sample(12'h800);
		send_sample(12'h555);
	endtask

	// zero group size behaves as one
	task automatic test_zero_group_size();
		write_group_size(8'd0);
		send_sample(12'hAAA);
		send_sample(12'd1);
		send_sample(12'd3999);
	endtask

	// group size lowered under a partial group closes it, mean saturates
	task automatic test_lowered_group_size();
		write_group_size(8'd4);
		send_sample(AVG_MAX);
		send_sample(AVG_MAX);
		write_group_size(8'd1);
		send_sample(AVG_MAX);
	endtask

	task automatic test_random_single();
		write_group_size(8'd1);
		run_random_samples(150);
	endtask

	task automatic test_random_full_group();
		write_group_size(MAX_SAMPLES);
		run_random_samples(255);
	endtask

	task automatic test_random_mid_sizes();
		write_group_size(8'd7);
		run_random_samples(140);
		write_group_size(8'($urandom_range(2, 16)));
		run_random_samples(100);
		write_group_size(8'($urandom_range(2, 16)));
		run_random_samples(100);
	endtask

	task automatic test_random_zero_size();
		write_group_size(8'd0);
		run_random_samples(100);
	endtask

	// sender stops mid-stream until the output side has caught up
	task automatic test_pause_until_drained();
		write_group_size(8'd2);
		run_random_samples(50);
		wait_drained();
		run_random_samples(50);
	endtask

	// receiver back-pressure: short stalls mostly, a few long ones
	always @(negedge clk) begin
		if (rx_stall_left > 0) begin
			rx_stall_left <= rx_stall_left - 1;
			out_ready     <= 1'b0;
		end else if (!rx_gaps_on) begin
			out_ready <= 1'b1;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 60) begin
				out_ready <= 1'b1;
			end else if (rx_roll < 93) begin
				out_ready     <= 1'b0;
				rx_stall_left <= $urandom_range(0, 3);
			end else begin
				out_ready     <= 1'b0;
				rx_stall_left <= $urandom_range(10, 40);
			end
		end
	end

	// result check on every output transfer
	always @(posedge clk) begin
		lux_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (lux_expect_q.size() == 0) begin
				report_mismatch("unexpected result, average", 32'(average), 0);
			end else begin
				want = lux_expect_q.pop_front();
				if (average !== want.average)
					report_mismatch("average", 32'(average), 32'(want.average));
				if (brightness_percent !== want.pct)
					report_mismatch("brightness_percent", 32'(brightness_percent),
						32'(want.pct));
				if (lux_value !== want.lux)
					report_mismatch("lux_value", 32'(lux_value), 32'(want.lux));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("timeout at %0t, %0d results outstanding", $realtime,
				lux_expect_q.size());
			$display("[light_adc_average_to_lux] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_group_size();
		test_single_sample_groups();
		test_zero_group_size();
		test_lowered_group_size();
		test_random_single();
		test_random_full_group();
		test_random_mid_sizes();
		test_random_zero_size();
		test_pause_until_drained();
		wait_drained();
		if (mismatch_count == 0) begin
			$display("[light_adc_average_to_lux] OK");
		end else begin
			$display("[light_adc_average_to_lux] ERROR");
		end
		$finish;
	end

endmodule
